// ----- src/kfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfm_pkg: shared types and constants for the first-match string search
// Pattern store depth, field widths, status codes and the control bundle
// that the top level broadcasts to the row of match cells.
// ----------------------------------------------------------------------------
package kfm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W       = 8;
  localparam int POS_W       = 24;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic             step;  // text byte runs through the cells
    logic             clr;   // drop all partial matches
    logic             load;  // pattern byte is written into one cell
    logic [SYM_W-1:0] sym;
  } kfm_ctrl_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] pos;
  } kfm_res_t;

endpackage
`default_nettype wire

// ----- src/kfm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfm_cell: one pattern position of the match row
// Holds one pattern byte and a flag that says the pattern prefix ending at
// this byte matches the text seen so far; the flag feeds the next cell.
// ----------------------------------------------------------------------------
module kfm_cell import kfm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire kfm_ctrl_t ctrl_i,
  input  wire logic      act_i,
  input  wire logic      en_i,
  input  wire logic      sel_i,
  input  wire logic      tail_i,
  output logic           hit_o,
  output logic           match_o
);

  logic [SYM_W-1:0] sym_q;
  logic             hit_q;
  logic             hit_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && sel_i) begin
      sym_q <= ctrl_i.sym;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.step) begin
      // extend the prefix from the left neighbor by this byte
      hit_d = act_i & en_i & (sym_q == ctrl_i.sym);
    end else if (ctrl_i.clr) begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o   = hit_q;
  assign match_o = ctrl_i.step & hit_d & tail_i;

endmodule
`default_nettype wire

// ----- src/kfm_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfm_out_stage: result register
// Holds one finished result until the consumer takes it, so the input side
// keeps moving whenever the register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module kfm_out_stage import kfm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire kfm_res_t res_i,
  output logic          full_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output kfm_res_t      res_o
);

  logic     valid_q;
  logic     valid_d;
  kfm_res_t res_q;
  logic     open;

  assign open         = ~valid_q | ~out_stall_i;
  assign full_stall_o = ~open;
  assign valid_d      = open ? push_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ----- src/kmp_first_match_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_first_match_search: first-match string search over a byte stream
// Pattern bytes load a row of match cells; text bytes then shift prefix
// match flags along the row, and the first full match position is reported.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, mode_i, symbol_i,   | consumer
//          | first_i, last_i                             |
//  out     | out_valid_o, out_stall_i, status_o,         | producer
//          | match_position_o                            |
//
// One item per cycle: each text byte of a live search is matched against all
// pattern cells at once, and its result is registered in the output register in the cycle after the
// transfer. The input stalls only while that register is full and stalled.
// Reset clears the length, flags, position and match flags; the pattern
// bytes themselves need no reset.
// ----------------------------------------------------------------------------
module kmp_first_match_search import kfm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             mode_i,
  input  wire logic [SYM_W-1:0] symbol_i,
  input  wire logic             first_i,
  input  wire logic             last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            status_o,
  output logic [POS_W-1:0]      match_position_o
);

  logic             accept;
  logic             is_pat;
  logic             is_text;
  logic [LEN_W-1:0] len_q, len_d, len_cur;
  logic             ovf_q, ovf_d;
  logic             found_q, found_d, found_cur;
  logic [POS_W-1:0] tp_q, tp_d, tp_cur;
  kfm_ctrl_t        ctrl;
  kfm_res_t         res;
  kfm_res_t         res_out;
  logic             full_stall;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] match;
  logic             hit_any;

  assign accept  = in_valid_i & ~in_stall_o;
  assign is_pat  = accept & (mode_i == MODE_PATTERN);
  assign is_text = accept & (mode_i == MODE_TEXT);
  assign in_stall_o = full_stall;

  // a new pattern starts from an empty store
  assign len_cur   = (is_pat && first_i) ? '0 : len_q;
  assign found_cur = first_i ? 1'b0 : found_q;
  assign tp_cur    = first_i ? '0 : tp_q;
  assign hit_any   = |match;

  always_comb begin
    len_d      = len_q;
    ovf_d      = ovf_q;
    found_d    = found_q;
    tp_d       = tp_q;
    ctrl.step  = 1'b0;
    ctrl.clr   = accept & first_i;
    ctrl.load  = 1'b0;
    ctrl.sym   = symbol_i;
    res.status = ST_PENDING;
    res.pos    = '0;
    if (is_pat) begin
      found_d = found_cur;
      tp_d    = tp_cur;
      if (first_i) begin
        ovf_d = 1'b0;
      end
      if (len_cur >= LEN_W'(MAX_PATTERN)) begin
        ovf_d      = 1'b1;
        res.status = ST_OVERFLOW;
      end else begin
        ctrl.load  = 1'b1;
        len_d      = len_cur + LEN_W'(1);
        res.status = (first_i || !ovf_q) ? ST_PENDING : ST_OVERFLOW;
      end
    end else if (is_text) begin
      found_d = found_cur;
      tp_d    = tp_cur;
      if (ovf_q) begin
        res.status = ST_OVERFLOW;
      end else if (found_cur) begin
        // hold the first match until a new search
        res.status = ST_FOUND;
        res.pos    = tp_cur - POS_W'(len_q);
      end else begin
        ctrl.step = 1'b1;
        tp_d      = tp_cur + POS_W'(1);
        if (hit_any) begin
          found_d    = 1'b1;
          res.status = ST_FOUND;
          res.pos    = tp_d - POS_W'(len_q);
        end else begin
          res.status = last_i ? ST_NOT_FOUND : ST_PENDING;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
      tp_q    <= '0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      found_q <= found_d;
      tp_q    <= tp_d;
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic act;
    if (k == 0) begin : g_head
      assign act = 1'b1;
    end else begin : g_body
      assign act = hit[k-1] & ~ctrl.clr;
    end

    kfm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .act_i   (act),
      .en_i    (LEN_W'(k) < len_cur),
      .sel_i   (LEN_W'(k) == len_cur),
      .tail_i  (LEN_W'(k + 1) == len_cur),
      .hit_o   (hit[k]),
      .match_o (match[k])
    );
  end

  kfm_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .res_i        (res),
    .full_stall_o (full_stall),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res_out)
  );

  assign status_o         = res_out.status;
  assign match_position_o = res_out.pos;

endmodule
`default_nettype wire
